// File: rtl/sin_pkg.sv
// Package for the slice index normalizer: port widths and the default index width.
// No dependencies; imported by the top level and by the divider.
package sin_pkg;

  localparam int LEN_WIDTH           = 63;  // sequence length and element count ports
  localparam int VAL_WIDTH           = 64;  // signed index and step ports
  localparam int DEFAULT_INDEX_WIDTH = 64;
  localparam int MIN_INDEX_WIDTH     = 16;

endpackage

// File: rtl/sin_div.sv
// Pipelined restoring divider for the slice normalizer: one quotient bit per stage.
// Carries an opaque sideband vector next to each item. Depends on sin_pkg.
module sin_div import sin_pkg::*; #(
  parameter int N  = DEFAULT_INDEX_WIDTH - 1,
  parameter int SW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [N-1:0]  in_num,
  input  logic [N-1:0]  in_div,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [N-1:0]  out_quot,
  output logic [SW-1:0] out_side
);

  logic          valid_r [N];
  logic [N-1:0]  rem_r   [N];
  logic [N-1:0]  nq_r    [N];  // numerator bits still to consume, quotient bits shifted in
  logic [N-1:0]  div_r   [N];
  logic [SW-1:0] side_r  [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic          valid_src;
    logic [N-1:0]  rem_src;
    logic [N-1:0]  nq_src;
    logic [N-1:0]  div_src;
    logic [SW-1:0] side_src;
    logic [N:0]    shifted;
    logic [N:0]    trial;
    logic          ge;

    if (k == 0) begin : g_first
      assign valid_src = in_valid;
      assign rem_src   = '0;
      assign nq_src    = in_num;
      assign div_src   = in_div;
      assign side_src  = in_side;
    end else begin : g_next
      assign valid_src = valid_r[k-1];
      assign rem_src   = rem_r[k-1];
      assign nq_src    = nq_r[k-1];
      assign div_src   = div_r[k-1];
      assign side_src  = side_r[k-1];
    end

    assign shifted = {rem_src, nq_src[N-1]};
    assign trial   = shifted - {1'b0, div_src};
    assign ge      = ~trial[N];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[k] <= 1'b0;
      end else if (en) begin
        valid_r[k] <= valid_src;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? trial[N-1:0] : shifted[N-1:0];
        nq_r[k]   <= {nq_src[N-2:0], ge};
        div_r[k]  <= div_src;
        side_r[k] <= side_src;
      end
    end
  end

  assign out_valid = valid_r[N-1];
  assign out_quot  = nq_r[N-1];
  assign out_side  = side_r[N-1];

endmodule

// File: rtl/slice_index_normalizer.sv
// Slice index normalizer: fills in absent slice bounds, wraps and clamps them,
// and counts the selected elements. Depends on sin_pkg and sin_div.
//
// Usage:
//   Input channel in_*: one transaction per slice request (length, start, stop,
//   step, each bound with a given flag). Output channel out_*: one transaction
//   per request, in order, with the adjusted start, stop, step, element count
//   and a zero-step error flag (all other result fields zero when it is set).
//   Throughput: one transaction per cycle while the output is not stalled.
//   Pipeline: three front-end stages (default and saturate, clamp,
//   difference), one divider stage per quotient bit (INDEX_WIDTH - 1 of
//   them) and the output register.
//   Stall: the whole pipeline holds while out_valid is high and out_stall is
//   high; in_stall follows that condition, so nothing is dropped or repeated.
//   Reset (rst_n low, synchronous) clears every valid bit; data registers are
//   left as they are. The block has no configuration and no stored state
//   between transactions.
module slice_index_normalizer import sin_pkg::*; #(
  parameter int INDEX_WIDTH = DEFAULT_INDEX_WIDTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [LEN_WIDTH-1:0]        in_seq_length,
  input  logic                        in_start_given,
  input  logic signed [VAL_WIDTH-1:0] in_start_value,
  input  logic                        in_stop_given,
  input  logic signed [VAL_WIDTH-1:0] in_stop_value,
  input  logic                        in_step_given,
  input  logic signed [VAL_WIDTH-1:0] in_step_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [VAL_WIDTH-1:0] out_start_out,
  output logic signed [VAL_WIDTH-1:0] out_stop_out,
  output logic signed [VAL_WIDTH-1:0] out_step_out,
  output logic [LEN_WIDTH-1:0]        out_element_count,
  output logic                        out_zero_step_error
);

  localparam int W  = INDEX_WIDTH;
  localparam int N  = W - 1;
  localparam int SW = 3 * W + 2;

  localparam logic [VAL_WIDTH-1:0]        IMAX_U = {{(VAL_WIDTH + 1 - W){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [VAL_WIDTH-1:0] IMAX_S = signed'(IMAX_U);
  localparam logic signed [VAL_WIDTH-1:0] IMIN_S = -IMAX_S - 64'sd1;
  localparam logic signed [W-1:0]         IMAX_W = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0]         IMIN_W = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [W-1:0]         ONE_W  = W'(1);
  localparam logic signed [W-1:0]         MONE_W = -ONE_W;

  function automatic logic signed [W-1:0] sat_idx(input logic signed [VAL_WIDTH-1:0] v);
    logic signed [W-1:0] r;
    if (v > IMAX_S) begin
      r = IMAX_W;
    end else if (v < IMIN_S) begin
      r = IMIN_W;
    end else begin
      r = W'(v);
    end
    return r;
  endfunction

  function automatic logic signed [W-1:0] clamp_bound(input logic signed [W-1:0] v,
                                                       input logic signed [W-1:0] len,
                                                       input logic               neg);
    logic signed [W-1:0] t;
    logic signed [W-1:0] r;
    t = v + len;
    if (v < 0) begin
      r = (t < 0) ? (neg ? MONE_W : '0) : t;
    end else if (v >= len) begin
      r = neg ? len - ONE_W : len;
    end else begin
      r = v;
    end
    return r;
  endfunction

  logic en;
  assign en       = ~out_valid | ~out_stall;
  assign in_stall = ~en;

  // Stage 1: saturate, default the bounds, resolve the step
  logic                valid1_r;
  logic signed [W-1:0] start1_r, stop1_r, step1_r, len1_r;
  logic                neg1_r, err1_r;

  logic signed [W-1:0] step_sat, step1_nxt, start1_nxt, stop1_nxt, len1_nxt;
  logic                err1_nxt, neg1_nxt;

  always_comb begin
    step_sat = sat_idx(in_step_value);
    err1_nxt = 1'b0;
    if (in_step_given) begin
      step1_nxt = (step_sat == IMIN_W) ? -IMAX_W : step_sat;
      err1_nxt  = (step_sat == '0);
    end else begin
      step1_nxt = ONE_W;
    end
    neg1_nxt   = step1_nxt[W-1];
    start1_nxt = in_start_given ? sat_idx(in_start_value) : (neg1_nxt ? IMAX_W : '0);
    stop1_nxt  = in_stop_given ? sat_idx(in_stop_value) : (neg1_nxt ? IMIN_W : IMAX_W);
    len1_nxt   = ({1'b0, in_seq_length} > IMAX_U) ? IMAX_W : W'(in_seq_length);
  end

  // Stage 2: wrap and clamp
  logic                valid2_r;
  logic signed [W-1:0] start2_r, stop2_r, step2_r;
  logic                neg2_r, err2_r;

  // Stage 3: difference, divisor magnitude, empty test
  logic                valid3_r;
  logic [N-1:0]        num3_r, div3_r;
  logic [SW-1:0]       side3_r;

  logic signed [W-1:0] diff3;
  logic                nonempty3;
  logic [N-1:0]        num3_nxt, div3_nxt;

  always_comb begin
    if (neg2_r) begin
      nonempty3 = stop2_r < start2_r;
      diff3     = start2_r - stop2_r - ONE_W;
      div3_nxt  = N'(-step2_r);
    end else begin
      nonempty3 = start2_r < stop2_r;
      diff3     = stop2_r - start2_r - ONE_W;
      div3_nxt  = N'(step2_r);
    end
    nonempty3 = nonempty3 & ~err2_r;
    num3_nxt  = nonempty3 ? N'(diff3) : '0;
    if (err2_r) begin
      div3_nxt = N'(ONE_W);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid1_r <= 1'b0;
      valid2_r <= 1'b0;
      valid3_r <= 1'b0;
    end else if (en) begin
      valid1_r <= in_valid;
      valid2_r <= valid1_r;
      valid3_r <= valid2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      start1_r <= start1_nxt;
      stop1_r  <= stop1_nxt;
      step1_r  <= step1_nxt;
      len1_r   <= len1_nxt;
      neg1_r   <= neg1_nxt;
      err1_r   <= err1_nxt;

      start2_r <= clamp_bound(start1_r, len1_r, neg1_r);
      stop2_r  <= clamp_bound(stop1_r, len1_r, neg1_r);
      step2_r  <= step1_r;
      neg2_r   <= neg1_r;
      err2_r   <= err1_r;

      num3_r   <= num3_nxt;
      div3_r   <= div3_nxt;
      side3_r  <= {err2_r, nonempty3, step2_r, stop2_r, start2_r};
    end
  end

  logic          dv_valid;
  logic [N-1:0]  dv_quot;
  logic [SW-1:0] dv_side;

  sin_div #(
    .N  (N),
    .SW (SW)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (valid3_r),
    .in_num    (num3_r),
    .in_div    (div3_r),
    .in_side   (side3_r),
    .out_valid (dv_valid),
    .out_quot  (dv_quot),
    .out_side  (dv_side)
  );

  // Output register
  logic                out_valid_r;
  logic signed [W-1:0] start_o_r, stop_o_r, step_o_r;
  logic [N-1:0]        count_o_r;
  logic                err_o_r;

  logic                dv_err, dv_nonempty;
  logic signed [W-1:0] dv_start, dv_stop, dv_step;

  assign {dv_err, dv_nonempty, dv_step, dv_stop, dv_start} = dv_side;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      err_o_r   <= dv_err;
      start_o_r <= dv_err ? '0 : dv_start;
      stop_o_r  <= dv_err ? '0 : dv_stop;
      step_o_r  <= dv_err ? '0 : dv_step;
      count_o_r <= dv_nonempty ? dv_quot + N'(1) : '0;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_start_out       = VAL_WIDTH'(start_o_r);
  assign out_stop_out        = VAL_WIDTH'(stop_o_r);
  assign out_step_out        = VAL_WIDTH'(step_o_r);
  assign out_element_count   = LEN_WIDTH'(count_o_r);
  assign out_zero_step_error = err_o_r;

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_step_error |-> out_step_out == '0 && out_element_count == '0)
    else $error("zero-step result carries nonzero fields");

  a_step_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_zero_step_error |-> out_step_out != '0)
    else $error("valid result has zero step");

  a_fwd_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_zero_step_error && !out_step_out[VAL_WIDTH-1] |->
      !out_start_out[VAL_WIDTH-1] && !out_stop_out[VAL_WIDTH-1])
    else $error("forward slice bound below zero");

  a_count_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_element_count != '0 |-> out_start_out != out_stop_out)
    else $error("nonempty count for equal bounds");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input held without a stalled result");

endmodule
